// ----- rtl/cwf_pkg.sv -----
// ----------------------------------------------------------------------------
// cwf_pkg
// shared types, register codes and arithmetic steps of the cone wind field
// ----------------------------------------------------------------------------
package cwf_pkg;

    localparam int COORD_W     = 32;
    localparam int FRAC_BITS   = 16;
    localparam int AXIS_W      = 16;
    localparam int AXIS_FRAC   = 14;
    localparam int SQRT_STEPS  = 32;
    localparam int FRAC_STEPS  = FRAC_BITS;
    localparam int QUO_STEPS   = 32;

    // stage positions along the valid chain
    localparam int ST_DIFF     = 0;
    localparam int ST_SQUARE   = 1;
    localparam int ST_SUM      = 2;
    localparam int ST_LEN      = ST_SUM + SQRT_STEPS + 1;
    localparam int ST_COS      = ST_LEN + FRAC_STEPS + 1;
    localparam int ST_SCALE    = ST_COS + FRAC_STEPS + 1;
    localparam int ST_SPEED    = ST_SCALE + 1;
    localparam int ST_COMP     = ST_SPEED + 1;
    localparam int ST_OUT      = ST_COMP + QUO_STEPS + 1;
    localparam int LATENCY     = ST_OUT + 1;

    localparam logic [16:0] FX_ONE  = 17'd65536;
    localparam logic [16:0] FX_HALF = 17'd32768;

    typedef enum logic [2:0] {
        REG_APEX_X    = 3'd0,
        REG_APEX_Y    = 3'd1,
        REG_APEX_Z    = 3'd2,
        REG_AXIS      = 3'd3,
        REG_COS_HALF  = 3'd4,
        REG_REACH     = 3'd5,
        REG_STRENGTH  = 3'd6
    } cwf_reg_e;

    typedef struct packed {
        logic signed [31:0] apex_x;
        logic signed [31:0] apex_y;
        logic signed [31:0] apex_z;
        logic [47:0]        axis_packed;
        logic signed [16:0] cos_half_angle;
        logic [30:0]        reach;
        logic [30:0]        strength;
    } cwf_cfg_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } cwf_point_t;

    typedef struct packed {
        logic signed [31:0] wind_x;
        logic signed [31:0] wind_y;
        logic signed [31:0] wind_z;
        logic               in_cone;
    } cwf_wind_t;

    // what travels along with every item
    typedef struct packed {
        logic [2:0]        neg;
        logic [2:0][30:0]  u;
        logic              kill;
    } cwf_side_t;

    typedef struct packed {
        cwf_side_t          side;
        logic signed [49:0] dot;
        logic [63:0]        x;
        logic [33:0]        rem;
        logic [31:0]        root;
        logic               zero;
    } cwf_sq_t;

    typedef struct packed {
        cwf_side_t          side;
        logic [31:0]        len;
        logic               cpos;
        logic               cfull;
        logic [45:0]        cden;
        logic [46:0]        crem;
        logic [15:0]        cq;
        logic [31:0]        srem;
        logic [15:0]        sq;
    } cwf_dv1_t;

    typedef struct packed {
        cwf_side_t          side;
        logic [31:0]        len;
        logic [15:0]        sd;
        logic               full;
        logic [17:0]        den;
        logic [18:0]        rem;
        logic [15:0]        q;
    } cwf_dv2_t;

    typedef struct packed {
        cwf_side_t          side;
        logic [31:0]        len;
        logic [16:0]        sa;
        logic [46:0]        mul;
    } cwf_scale_t;

    typedef struct packed {
        cwf_side_t          side;
        logic [31:0]        len;
        logic [31:0]        speed;
    } cwf_speed_t;

    typedef struct packed {
        logic [2:0]        neg;
        logic              kill;
        logic [31:0]       len;
        logic [2:0][31:0]  rem;
        logic [2:0][31:0]  x;
        logic [2:0][31:0]  q;
    } cwf_dv3_t;

    // one digit pair of the square root
    function automatic cwf_sq_t sqrt_step(input cwf_sq_t s);
        cwf_sq_t     n;
        logic [35:0] rn;
        logic [35:0] t;
        logic [35:0] diff;
        n    = s;
        rn   = {s.rem, s.x[63:62]};
        t    = {2'b00, s.root, 2'b01};
        diff = rn - t;
        n.x  = {s.x[61:0], 2'b00};
        if (rn >= t)
        begin
            n.rem  = diff[33:0];
            n.root = {s.root[30:0], 1'b1};
        end
        else
        begin
            n.rem  = rn[33:0];
            n.root = {s.root[30:0], 1'b0};
        end
        return n;
    endfunction

endpackage

// ----- rtl/cwf_regs.sv -----
// ----------------------------------------------------------------------------
// cwf_regs
// configuration register file behind the apb port
// ----------------------------------------------------------------------------
module cwf_regs import cwf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output cwf_cfg_t    cfg
);

    cwf_cfg_t cfg_reg;
    cwf_reg_e sel;
    logic     wr_en;

    assign pready = 1'b1;
    assign sel    = cwf_reg_e'(paddr[5:3]);
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.apex_x         <= '0;
            cfg_reg.apex_y         <= '0;
            cfg_reg.apex_z         <= '0;
            cfg_reg.axis_packed    <= 48'd16384;
            cfg_reg.cos_half_angle <= 17'sd46341;
            cfg_reg.reach          <= 31'd65536;
            cfg_reg.strength       <= 31'd65536;
        end
        else if (wr_en)
        begin
            case (sel)
                REG_APEX_X:   cfg_reg.apex_x         <= pwdata[31:0];
                REG_APEX_Y:   cfg_reg.apex_y         <= pwdata[31:0];
                REG_APEX_Z:   cfg_reg.apex_z         <= pwdata[31:0];
                REG_AXIS:     cfg_reg.axis_packed    <= pwdata[47:0];
                REG_COS_HALF: cfg_reg.cos_half_angle <= pwdata[16:0];
                REG_REACH:    cfg_reg.reach          <= pwdata[30:0];
                REG_STRENGTH: cfg_reg.strength       <= pwdata[30:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_APEX_X:   prdata = {32'd0, cfg_reg.apex_x};
            REG_APEX_Y:   prdata = {32'd0, cfg_reg.apex_y};
            REG_APEX_Z:   prdata = {32'd0, cfg_reg.apex_z};
            REG_AXIS:     prdata = {16'd0, cfg_reg.axis_packed};
            REG_COS_HALF: prdata = {47'd0, cfg_reg.cos_half_angle};
            REG_REACH:    prdata = {33'd0, cfg_reg.reach};
            REG_STRENGTH: prdata = {33'd0, cfg_reg.strength};
            default:      prdata = '0;
        endcase
    end

endmodule

// ----- rtl/cone_wind_field.sv -----
// ----------------------------------------------------------------------------
// cone_wind_field
// wind velocity at a query point from a cone-shaped fan, q16.16 fixed point
// ----------------------------------------------------------------------------
// channel   direction  handshake                     payload
// point     in         start, busy (accept: start & !busy)  cwf_point_t
// wind      out        done, one cycle, no backpressure    cwf_wind_t
// apb       in/out     psel, penable, pwrite, pready       paddr, pwdata, prdata
//
// one item enters every cycle; busy is never raised
// each result passes through the 32-stage square root, two 16-stage fraction
// dividers and the 32-stage component divider
// reset clears the valid chain and the fan registers; items in flight are dropped
// results cannot be stalled, so nothing in the pipe ever waits
// ----------------------------------------------------------------------------
module cone_wind_field import cwf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  cwf_point_t  point,
    output logic        done,
    output cwf_wind_t   wind,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    cwf_cfg_t cfg;

    cwf_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // valid chain, one bit per stage
    logic [LATENCY-1:0] vld_reg;

    assign busy = 1'b0;
    assign done = vld_reg[ST_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LATENCY-2:0], start & ~busy};
    end

    // offset from the apex
    logic signed [32:0] d_reg [3];
    logic signed [32:0] d_next [3];

    always_comb
    begin
        d_next[0] = {point.pos_x[31], point.pos_x} - {cfg.apex_x[31], cfg.apex_x};
        d_next[1] = {point.pos_y[31], point.pos_y} - {cfg.apex_y[31], cfg.apex_y};
        d_next[2] = {point.pos_z[31], point.pos_z} - {cfg.apex_z[31], cfg.apex_z};
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
    end

    // magnitudes, reach box test, squares and axis products
    cwf_side_t          side2_reg, side2_next;
    logic [61:0]        sqr_reg [3];
    logic [61:0]        sqr_next [3];
    logic signed [47:0] prod_reg [3];
    logic signed [47:0] prod_next [3];

    always_comb
    begin
        logic [32:0] ua;
        side2_next.kill = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            ua = d_reg[i][32] ? 33'(-d_reg[i]) : 33'(d_reg[i]);
            if (ua > {2'b00, cfg.reach})
                side2_next.kill = 1'b1;
            side2_next.neg[i] = d_reg[i][32];
            side2_next.u[i]   = ua[30:0];
            sqr_next[i]       = ua[30:0] * ua[30:0];
            prod_next[i]      = $signed(d_reg[i][31:0])
                              * $signed(cfg.axis_packed[i*AXIS_W +: AXIS_W]);
        end
    end

    always_ff @(posedge clk)
    begin
        side2_reg <= side2_next;
        sqr_reg   <= sqr_next;
        prod_reg  <= prod_next;
    end

    // squared length and dot product, then the root digit by digit
    cwf_sq_t sq_reg [SQRT_STEPS+1];
    cwf_sq_t sq_next;

    always_comb
    begin
        sq_next.side = side2_reg;
        sq_next.x    = 64'(sqr_reg[0]) + 64'(sqr_reg[1]) + 64'(sqr_reg[2]);
        sq_next.dot  = 50'(prod_reg[0]) + 50'(prod_reg[1]) + 50'(prod_reg[2]);
        sq_next.rem  = '0;
        sq_next.root = '0;
        sq_next.zero = (sq_next.x == 64'd0);
    end

    always_ff @(posedge clk)
    begin
        sq_reg[0] <= sq_next;
    end

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        always_ff @(posedge clk)
        begin
            sq_reg[k+1] <= sqrt_step(sq_reg[k]);
        end
    end

    // length checks, then cosine and distance falloff fractions side by side
    cwf_dv1_t dv1_reg [FRAC_STEPS+1];
    cwf_dv1_t dv1_next;

    always_comb
    begin
        cwf_sq_t s;
        s              = sq_reg[SQRT_STEPS];
        dv1_next.side  = s.side;
        dv1_next.len   = s.root;
        if (s.zero || (s.root > {1'b0, cfg.reach}))
            dv1_next.side.kill = 1'b1;
        dv1_next.cden  = {s.root, 14'd0};
        dv1_next.cpos  = (s.dot > 50'sd0);
        dv1_next.cfull = (s.dot >= $signed({4'd0, dv1_next.cden}));
        dv1_next.crem  = {1'b0, s.dot[45:0]};
        dv1_next.cq    = '0;
        dv1_next.srem  = {1'b0, cfg.reach} - s.root;
        dv1_next.sq    = '0;
    end

    always_ff @(posedge clk)
    begin
        dv1_reg[0] <= dv1_next;
    end

    for (genvar k = 0; k < FRAC_STEPS; k++)
    begin : g_div1
        cwf_dv1_t n;
        always_comb
        begin
            logic [46:0] crn;
            logic [31:0] srn;
            n   = dv1_reg[k];
            crn = {dv1_reg[k].crem[45:0], 1'b0};
            srn = {dv1_reg[k].srem[30:0], 1'b0};
            if (crn >= {1'b0, dv1_reg[k].cden})
            begin
                n.crem = crn - {1'b0, dv1_reg[k].cden};
                n.cq   = {dv1_reg[k].cq[14:0], 1'b1};
            end
            else
            begin
                n.crem = crn;
                n.cq   = {dv1_reg[k].cq[14:0], 1'b0};
            end
            if (srn >= {1'b0, cfg.reach})
            begin
                n.srem = srn - {1'b0, cfg.reach};
                n.sq   = {dv1_reg[k].sq[14:0], 1'b1};
            end
            else
            begin
                n.srem = srn;
                n.sq   = {dv1_reg[k].sq[14:0], 1'b0};
            end
        end
        always_ff @(posedge clk)
        begin
            dv1_reg[k+1] <= n;
        end
    end

    // cone test and angular fraction
    cwf_dv2_t dv2_reg [FRAC_STEPS+1];
    cwf_dv2_t dv2_next;

    always_comb
    begin
        cwf_dv1_t           s;
        logic [16:0]        cosq;
        logic signed [18:0] c19;
        logic signed [18:0] num;
        logic signed [18:0] den;
        s    = dv1_reg[FRAC_STEPS];
        cosq = !s.cpos ? 17'd0 : (s.cfull ? FX_ONE : {1'b0, s.cq});
        c19  = {{2{cfg.cos_half_angle[16]}}, cfg.cos_half_angle};
        num  = $signed({2'b00, cosq}) - c19;
        den  = $signed({2'b00, FX_ONE}) - c19;
        dv2_next.side = s.side;
        if ($signed({2'b00, cosq}) < c19)
            dv2_next.side.kill = 1'b1;
        dv2_next.len  = s.len;
        dv2_next.sd   = s.sq;
        dv2_next.full = (num >= den);
        dv2_next.den  = den[17:0];
        dv2_next.rem  = num;
        dv2_next.q    = '0;
    end

    always_ff @(posedge clk)
    begin
        dv2_reg[0] <= dv2_next;
    end

    for (genvar k = 0; k < FRAC_STEPS; k++)
    begin : g_div2
        cwf_dv2_t n;
        always_comb
        begin
            logic [18:0] rn;
            n  = dv2_reg[k];
            rn = {dv2_reg[k].rem[17:0], 1'b0};
            if (rn >= {1'b0, dv2_reg[k].den})
            begin
                n.rem = rn - {1'b0, dv2_reg[k].den};
                n.q   = {dv2_reg[k].q[14:0], 1'b1};
            end
            else
            begin
                n.rem = rn;
                n.q   = {dv2_reg[k].q[14:0], 1'b0};
            end
        end
        always_ff @(posedge clk)
        begin
            dv2_reg[k+1] <= n;
        end
    end

    // angular term floored at one half, strength times falloff
    cwf_scale_t sc_reg, sc_next;

    always_comb
    begin
        cwf_dv2_t s;
        s            = dv2_reg[FRAC_STEPS];
        sc_next.side = s.side;
        sc_next.len  = s.len;
        sc_next.sa   = s.full ? FX_ONE : {1'b0, s.q};
        if (sc_next.sa < FX_HALF)
            sc_next.sa = FX_HALF;
        sc_next.mul  = cfg.strength * s.sd;
    end

    always_ff @(posedge clk)
    begin
        sc_reg <= sc_next;
    end

    // speed
    cwf_speed_t sp_reg, sp_next;

    always_comb
    begin
        logic [47:0] p;
        p            = sc_reg.mul[46:16] * sc_reg.sa;
        sp_next.side = sc_reg.side;
        sp_next.len  = sc_reg.len;
        sp_next.speed = p[47:16];
    end

    always_ff @(posedge clk)
    begin
        sp_reg <= sp_next;
    end

    // speed times each magnitude, divided by the length
    cwf_dv3_t dv3_reg [QUO_STEPS+1];
    cwf_dv3_t dv3_next;

    always_comb
    begin
        logic [62:0] p;
        dv3_next.neg  = sp_reg.side.neg;
        dv3_next.kill = sp_reg.side.kill;
        dv3_next.len  = sp_reg.len;
        for (int i = 0; i < 3; i++)
        begin
            p              = sp_reg.speed * sp_reg.side.u[i];
            dv3_next.rem[i] = {1'b0, p[62:32]};
            dv3_next.x[i]   = p[31:0];
            dv3_next.q[i]   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        dv3_reg[0] <= dv3_next;
    end

    for (genvar k = 0; k < QUO_STEPS; k++)
    begin : g_div3
        cwf_dv3_t n;
        always_comb
        begin
            logic [32:0] rn;
            logic [32:0] diff;
            n = dv3_reg[k];
            for (int i = 0; i < 3; i++)
            begin
                rn      = {dv3_reg[k].rem[i], dv3_reg[k].x[i][31]};
                diff    = rn - {1'b0, dv3_reg[k].len};
                n.x[i]  = {dv3_reg[k].x[i][30:0], 1'b0};
                if (rn >= {1'b0, dv3_reg[k].len})
                begin
                    n.rem[i] = diff[31:0];
                    n.q[i]   = {dv3_reg[k].q[i][30:0], 1'b1};
                end
                else
                begin
                    n.rem[i] = rn[31:0];
                    n.q[i]   = {dv3_reg[k].q[i][30:0], 1'b0};
                end
            end
        end
        always_ff @(posedge clk)
        begin
            dv3_reg[k+1] <= n;
        end
    end

    // signs, saturation and the zero result outside the cone
    cwf_wind_t  wind_reg, wind_next;
    logic [31:0] comp [3];

    always_comb
    begin
        cwf_dv3_t           s;
        logic signed [32:0] v;
        s = dv3_reg[QUO_STEPS];
        for (int i = 0; i < 3; i++)
        begin
            v = s.neg[i] ? -$signed({1'b0, s.q[i]}) : $signed({1'b0, s.q[i]});
            if (v > 33'sh0_7FFF_FFFF)
                comp[i] = 32'h7FFF_FFFF;
            else if (v < -33'sh0_8000_0000)
                comp[i] = 32'h8000_0000;
            else
                comp[i] = v[31:0];
            if (s.kill)
                comp[i] = '0;
        end
        wind_next.wind_x  = comp[0];
        wind_next.wind_y  = comp[1];
        wind_next.wind_z  = comp[2];
        wind_next.in_cone = ~s.kill;
    end

    always_ff @(posedge clk)
    begin
        wind_reg <= wind_next;
    end

    assign wind = wind_reg;

    // a point outside the cone carries no wind
    a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
        done && !wind.in_cone |-> wind.wind_x == 0 && wind.wind_y == 0
                                  && wind.wind_z == 0)
        else $error("wind outside cone");

    // a surviving item never reaches the dividers with zero length
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_LEN] && !dv1_reg[0].side.kill |-> dv1_reg[0].len != 0)
        else $error("zero length past the root");

    // speed stays below 2^31, so components never need clamping
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_SPEED] |-> !sp_reg.speed[31])
        else $error("speed out of range");

    // the x component never exceeds the speed that made it
    a_comp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_OUT - 1] && !dv3_reg[QUO_STEPS].kill
            |-> dv3_reg[QUO_STEPS].q[0] <= $past(sp_reg.speed, QUO_STEPS + 1))
        else $error("component above speed");

endmodule

// ----- tb/sv/cone_wind_field_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cone_wind_field_tb
// self-checking bench: points go in through start/busy, winds are compared
// against a fixed-point predictor of the cone fan, fan settings change via apb
// ----------------------------------------------------------------------------

import cwf_pkg::*;

// keeps the expected winds in arrival order and the mismatch tally
class wind_scoreboard;
    cwf_cfg_t  fan;
    cwf_wind_t pending[$];
    int        mismatches;
    int        checked;

    function new();
        mismatches = 0;
        checked    = 0;
    endfunction

    // a/b with 16 fractional bits, num < den
    function automatic longint unsigned frac16(longint unsigned num,
                                               longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = 0;
        rem = num;
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                q   = q | 1;
            end
        end
        return q;
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic cwf_wind_t fan_wind(cwf_point_t p);
        cwf_wind_t       w;
        longint          d[3];
        longint unsigned u[3];
        longint unsigned sum, len, cosq, sa, sd, speed, m, rch;
        longint          dot, c, num, den, s;
        logic signed [15:0] ax;
        logic            out_of;
        w      = '0;
        rch    = fan.reach;
        d[0]   = longint'(p.pos_x) - longint'(fan.apex_x);
        d[1]   = longint'(p.pos_y) - longint'(fan.apex_y);
        d[2]   = longint'(p.pos_z) - longint'(fan.apex_z);
        out_of = 0;
        sum    = 0;
        for (int i = 0; i < 3; i++)
        begin
            u[i] = (d[i] < 0) ? longint'(-d[i]) : longint'(d[i]);
            if (u[i] > rch)
                out_of = 1;
        end
        if (out_of)
            return w;
        for (int i = 0; i < 3; i++)
            sum = sum + u[i] * u[i];
        if (sum == 0)
            return w;
        len = root64(sum);
        if (len > rch)
            return w;
        dot = 0;
        for (int i = 0; i < 3; i++)
        begin
            ax  = fan.axis_packed[16*i +: 16];
            dot = dot + d[i] * longint'(ax);
        end
        if (dot <= 0)
            cosq = 0;
        else if (unsigned'(dot) >= (len << AXIS_FRAC))
            cosq = 65536;
        else
            cosq = frac16(dot, len << AXIS_FRAC);
        c = longint'(fan.cos_half_angle);
        if (longint'(cosq) < c)
            return w;
        num = longint'(cosq) - c;
        den = 65536 - c;
        sa  = (num >= den) ? 65536 : frac16(num, den);
        if (sa < 32768)
            sa = 32768;
        sd    = frac16(rch - len, rch);
        speed = (((64'(fan.strength) * sd) >> FRAC_BITS) * sa) >> FRAC_BITS;
        for (int i = 0; i < 3; i++)
        begin
            m = speed * u[i] / len;
            s = (d[i] < 0) ? -longint'(m) : longint'(m);
            if (s > 64'sd2147483647)
                s = 64'sd2147483647;
            if (s < -64'sd2147483648)
                s = -64'sd2147483648;
            case (i)
                0: w.wind_x = s[31:0];
                1: w.wind_y = s[31:0];
                default: w.wind_z = s[31:0];
            endcase
        end
        w.in_cone = 1'b1;
        return w;
    endfunction

    function void note_point(cwf_point_t p);
        pending.push_back(fan_wind(p));
    endfunction

    function void check_wind(cwf_wind_t got);
        cwf_wind_t exp_w;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected wind %h", got);
            return;
        end
        exp_w = pending.pop_front();
        checked++;
        if (got.wind_x !== exp_w.wind_x || got.wind_y !== exp_w.wind_y ||
            got.wind_z !== exp_w.wind_z || got.in_cone !== exp_w.in_cone)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("wind mismatch: exp %h %h %h %b got %h %h %h %b",
                         exp_w.wind_x, exp_w.wind_y, exp_w.wind_z, exp_w.in_cone,
                         got.wind_x, got.wind_y, got.wind_z, got.in_cone);
        end
    endfunction
endclass

module cone_wind_field_tb;

    localparam int WATCHDOG = 20000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cwf_point_t  point;
    logic        done;
    cwf_wind_t   wind;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    wind_scoreboard board;
    int             idle_cycles;
    int             points_in;
    int             in_cone_seen;

    cone_wind_field dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .point   (point),
        .done    (done),
        .wind    (wind),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // scoreboard side: note accepted points, check every done strobe
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                board.note_point(point);
                points_in++;
            end
            if (done)
            begin
                board.check_wind(wind);
                if (wind.in_cone)
                    in_cone_seen++;
            end
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // watchdog: no item accepted or produced for too long
    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG)
        begin
            $display("watchdog expired");
            $display("FAIL");
            $finish;
        end
    end

    // register write; fan copy updated at the same edge the block takes it
    task automatic write_reg(cwf_reg_e idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 6'(idx) << 3;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_APEX_X:   board.fan.apex_x         = value[31:0];
            REG_APEX_Y:   board.fan.apex_y         = value[31:0];
            REG_APEX_Z:   board.fan.apex_z         = value[31:0];
            REG_AXIS:     board.fan.axis_packed    = value[47:0];
            REG_COS_HALF: board.fan.cos_half_angle = value[16:0];
            REG_REACH:    board.fan.reach          = value[30:0];
            default:      board.fan.strength       = value[30:0];
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_fan(cwf_cfg_t f);
        write_reg(REG_APEX_X, 64'(f.apex_x));
        write_reg(REG_APEX_Y, 64'(f.apex_y));
        write_reg(REG_APEX_Z, 64'(f.apex_z));
        write_reg(REG_AXIS, 64'(f.axis_packed));
        write_reg(REG_COS_HALF, 64'(f.cos_half_angle));
        write_reg(REG_REACH, 64'(f.reach));
        write_reg(REG_STRENGTH, 64'(f.strength));
    endtask

    // hand one point over; start stays high across back-to-back items
    task automatic send_point(cwf_point_t p, bit keep);
        start <= 1'b1;
        point <= p;
        do
            @(posedge clk);
        while (busy);
        if (!keep)
            start <= 1'b0;
    endtask

    // bursts of random length with random gaps, including no gaps at all
    task automatic send_burst_run(int count, int near_pct);
        cwf_point_t p;
        int         burst;
        burst = 0;
        for (int n = 0; n < count; n++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
            end
            burst--;
            if ($urandom_range(0, 99) < near_pct)
            begin
                // mostly within reach so cone and speed logic get exercised
                p.pos_x = board.fan.apex_x + signed'(32'($urandom_range(0, 2 * board.fan.reach))
                          - 32'(board.fan.reach));
                p.pos_y = board.fan.apex_y + signed'(32'($urandom_range(0, board.fan.reach))
                          - 32'(board.fan.reach / 2));
                p.pos_z = board.fan.apex_z + signed'(32'($urandom_range(0, board.fan.reach))
                          - 32'(board.fan.reach / 2));
            end
            else
            begin
                p.pos_x = $urandom;
                p.pos_y = $urandom;
                p.pos_z = $urandom;
            end
            send_point(p, 1'b1);
        end
        start <= 1'b0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    function automatic logic [47:0] pack_axis(int x, int y, int z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    initial
    begin
        cwf_config_local();
    end

    task automatic cwf_config_local();
        cwf_cfg_t   f;
        cwf_point_t p;
        board        = new();
        idle_cycles  = 0;
        points_in    = 0;
        in_cone_seen = 0;
        rst_n   = 1'b0;
        start   = 1'b0;
        point   = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        // reset values of the fan
        board.fan.apex_x         = '0;
        board.fan.apex_y         = '0;
        board.fan.apex_z         = '0;
        board.fan.axis_packed    = 48'd16384;
        board.fan.cos_half_angle = 17'd46341;
        board.fan.reach          = 31'd65536;
        board.fan.strength       = 31'd65536;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed points against the reset fan: apex, axis, edges, extremes
        send_point('{32'sd0, 32'sd0, 32'sd0}, 1);
        send_point('{32'sd32768, 32'sd0, 32'sd0}, 1);
        send_point('{32'sd65536, 32'sd0, 32'sd0}, 1);
        send_point('{32'sd65537, 32'sd0, 32'sd0}, 1);
        send_point('{-32'sd32768, 32'sd0, 32'sd0}, 1);
        send_point('{32'sd30000, 32'sd30000, 32'sd0}, 1);
        send_point('{32'sd30000, 32'sd10000, -32'sd10000}, 1);
        send_point('{32'sd1, 32'sd0, 32'sd0}, 1);
        send_point('{32'sd40000, 32'sd40000, 32'sd40000}, 1);
        send_point('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff}, 1);
        send_point('{32'h80000000, 32'h80000000, 32'h80000000}, 1);
        send_point('{32'sd0, 32'sd20000, 32'sd0}, 0);
        drain();

        // huge reach and strength, negative cone cosine, apex at an extreme
        f.apex_x         = 32'h80000000;
        f.apex_y         = 32'h7fffffff;
        f.apex_z         = 32'sd0;
        f.axis_packed    = pack_axis(9459, 9459, 0);
        f.cos_half_angle = 17'h10000;
        f.reach          = 31'h7fffffff;
        f.strength       = 31'h7fffffff;
        set_fan(f);
        send_point('{32'h7fffffff, 32'h80000000, 32'sd0}, 1);
        send_point('{32'h80000000, 32'h7fffffff, 32'sd0}, 1);
        send_point('{32'h80000001, 32'h7ffffffe, 32'sd5}, 1);
        send_point('{32'sd0, 32'sd0, 32'sd0}, 1);
        send_point('{32'hc0000000, 32'h40000000, 32'h40000000}, 1);
        send_burst_run(150, 50);
        drain();

        // tiny reach, zero strength, cone cosine at its top
        f.apex_x         = 32'sd100;
        f.apex_y         = -32'sd100;
        f.apex_z         = 32'sd7;
        f.axis_packed    = pack_axis(0, 0, -16384);
        f.cos_half_angle = 17'h0ffff;
        f.reach          = 31'd1;
        f.strength       = 31'd0;
        set_fan(f);
        send_point('{32'sd100, -32'sd100, 32'sd6}, 1);
        send_point('{32'sd101, -32'sd100, 32'sd7}, 1);
        send_burst_run(100, 80);
        drain();

        // random fans, mostly moderate sizes
        for (int phase = 0; phase < 10; phase++)
        begin
            f.apex_x         = $urandom;
            f.apex_y         = $urandom;
            f.apex_z         = $urandom;
            f.axis_packed    = 48'({$urandom, $urandom});
            f.cos_half_angle = $urandom_range(0, 3) == 0 ? 17'($urandom)
                                : 17'($urandom_range(0, 60000));
            f.reach          = $urandom_range(0, 3) == 0 ? 31'($urandom)
                                : 31'($urandom_range(1, 1 << 22));
            f.strength       = 31'($urandom);
            if (phase % 2 == 0)
                f.axis_packed = pack_axis($urandom_range(0, 1) ? 16384 : -16384,
                                          $urandom_range(0, 4000), 0);
            set_fan(f);
            send_burst_run(125, 85);
            drain();
        end

        $display("%0d points checked across 13 fan settings, %0d inside the cone",
                 board.checked, in_cone_seen);
        if (board.mismatches == 0 && board.pending.size() == 0
            && board.checked == points_in)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    endtask

endmodule
